[sv/ssdc_pkg.sv]
// ----------------------------------------------------------------------------
// ssdc_pkg
// Shared types and constants for the steering stepper deadzone controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdc_pkg;

  // Mode codes carried on the mode field.
  localparam logic [1:0] ModeRc    = 2'd0;
  localparam logic [1:0] ModeWheel = 2'd1;
  localparam logic [1:0] ModeHold  = 2'd2;

  // Configuration register indexes.
  localparam logic RegDeadzone = 1'b0;
  localparam logic RegPulses   = 1'b1;

  localparam logic [7:0] DeadzoneReset = 8'd10;
  localparam logic [7:0] PulsesReset   = 8'd15;

  // Encoder sample divided by ten: floor(raw * 3277 / 2^15) is exact below 2^14.
  localparam int EncRecip = 3277;
  localparam int EncShift = 15;

  // Wheel mapping: 170 + wheel * 195 / 655 = 170 + (wheel * 39) / 131.
  localparam int WheelMax   = 655;
  localparam int WheelMul   = 39;
  localparam int TargetLo   = 170;
  localparam int WheelShift = 23;
  localparam int WheelRecip = (2**WheelShift + 130) / 131;

  localparam int SampleW = 9;
  localparam int SumW    = 13;
  localparam int WScaleW = 15;

  // Item after the input register, with the encoder division by ten done and the wheel value multiplied by 39.
  typedef struct packed {
    logic [1:0]         mode;
    logic [SampleW-1:0] sample;
    logic [9:0]         rc_target;
    logic [WScaleW-1:0] wheel_scaled;
  } item_t;

  typedef struct packed {
    logic [7:0] deadzone;
    logic [7:0] pulses_per_command;
  } cfg_t;

endpackage

`default_nettype wire

[sv/steering_stepper_deadzone_ctrl.sv]
// A request is captured in the input register and its result in the result register.
// Throughput: one item per cycle while the output is not stalled; the ring, running sum
// and decision are computed combinationally between the input register and the result register.
// Reset: the sample ring, ring pointer and window sum clear to zero, and the
// deadzone and pulse count registers return to 10 and 15.
// ----------------------------------------------------------------------------
// steering_stepper_deadzone_ctrl
// Moving-average steering position filter with a deadband stepper command.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_stepper_deadzone_ctrl #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [11:0] encoder_raw_i,
  input  wire logic [9:0]  rc_target_i,
  input  wire logic [9:0]  wheel_position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             step_enable_o,
  output logic             turn_right_o,
  output logic [7:0]       pulse_count_o,
  output logic [8:0]       filtered_position_o
);

  ssdc_pkg::cfg_t  cfg_q, cfg_d;
  ssdc_pkg::item_t item;
  logic            item_valid, take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ssdc_pkg::RegDeadzone: cfg_d.deadzone           = cfg_wdata_i;
        ssdc_pkg::RegPulses:   cfg_d.pulses_per_command = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone           <= ssdc_pkg::DeadzoneReset;
      cfg_q.pulses_per_command <= ssdc_pkg::PulsesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssdc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .encoder_raw_i    (encoder_raw_i),
    .rc_target_i      (rc_target_i),
    .wheel_position_i (wheel_position_i),
    .take_i           (take),
    .item_valid_o     (item_valid),
    .item_o           (item)
  );

  ssdc_core #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .item_valid_i        (item_valid),
    .item_i              (item),
    .cfg_i               (cfg_q),
    .take_o              (take),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .step_enable_o       (step_enable_o),
    .turn_right_o        (turn_right_o),
    .pulse_count_o       (pulse_count_o),
    .filtered_position_o (filtered_position_o)
  );

endmodule

`default_nettype wire

[sv/ssdc_front.sv]
// ----------------------------------------------------------------------------
// ssdc_front
// Input register: scales the encoder sample and the wheel value on the way in.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [11:0]      encoder_raw_i,
  input  wire logic [9:0]       rc_target_i,
  input  wire logic [9:0]       wheel_position_i,
  input  wire logic             take_i,
  output logic                  item_valid_o,
  output ssdc_pkg::item_t       item_o
);

  logic            valid_q, valid_d;
  ssdc_pkg::item_t item_q, item_d;
  logic [23:0]     enc_prod;
  logic [9:0]      wheel_sat;
  logic [ssdc_pkg::WScaleW-1:0] wheel_prod;

  assign in_ready_o = !valid_q || take_i;

  assign enc_prod  = {12'd0, encoder_raw_i} * 24'(ssdc_pkg::EncRecip);
  assign wheel_sat = (wheel_position_i > 10'(ssdc_pkg::WheelMax)) ?
                     10'(ssdc_pkg::WheelMax) : wheel_position_i;
  assign wheel_prod = {5'd0, wheel_sat} * ssdc_pkg::WScaleW'(ssdc_pkg::WheelMul);

  always_comb begin
    item_d.mode         = mode_i;
    item_d.sample       = enc_prod[ssdc_pkg::EncShift +: ssdc_pkg::SampleW];
    item_d.rc_target    = rc_target_i;
    item_d.wheel_scaled = wheel_prod;
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[sv/ssdc_core.sv]
// ----------------------------------------------------------------------------
// ssdc_core
// Moving-average ring, target selection, deadband decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdc_core #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire ssdc_pkg::item_t  item_i,
  input  wire ssdc_pkg::cfg_t   cfg_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  step_enable_o,
  output logic                  turn_right_o,
  output logic [7:0]            pulse_count_o,
  output logic [8:0]            filtered_position_o
);

  localparam int PtrW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SumShift = ssdc_pkg::SumW + 4;
  localparam int RecipW   = SumShift + 1;
  localparam int ProdW    = ssdc_pkg::SumW + RecipW;
  localparam logic [RecipW-1:0] SumRecip =
    RecipW'((2**SumShift + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [ssdc_pkg::SampleW-1:0] ring_q [WINDOW_LEN];
  logic [PtrW-1:0]              ptr_q, ptr_d;
  logic [ssdc_pkg::SumW-1:0]    sum_q, sum_d;
  logic [ProdW-1:0]             sum_prod;
  logic [8:0]                   filtered;
  logic [31:0]                  wheel_prod;
  logic [9:0]                   target, filt_ext, mag;
  logic                         active, above, enable, advance;

  logic       out_valid_q;
  logic       step_enable_q, turn_right_q;
  logic [7:0] pulse_count_q;
  logic [8:0] filtered_q;

  assign take_o  = !out_valid_q || out_ready_i;
  assign advance = take_o && item_valid_i;

  // The oldest sample leaves the window as the new one enters.
  assign sum_d    = sum_q - ssdc_pkg::SumW'(ring_q[ptr_q])
                  + ssdc_pkg::SumW'(item_i.sample);
  assign sum_prod = {{RecipW{1'b0}}, sum_d} * {{ssdc_pkg::SumW{1'b0}}, SumRecip};
  assign filtered = sum_prod[SumShift +: 9];
  assign ptr_d    = (ptr_q == PtrW'(WINDOW_LEN - 1)) ? '0 : ptr_q + PtrW'(1);

  assign wheel_prod = {17'd0, item_i.wheel_scaled} * 32'(ssdc_pkg::WheelRecip);

  always_comb begin
    active = 1'b1;
    case (item_i.mode)
      ssdc_pkg::ModeRc:    target = item_i.rc_target;
      ssdc_pkg::ModeWheel: target = 10'(ssdc_pkg::TargetLo)
                                  + {1'b0, wheel_prod[ssdc_pkg::WheelShift +: 9]};
      default: begin
        target = '0;
        active = 1'b0;
      end
    endcase
    filt_ext = {1'b0, filtered};
    above    = target > filt_ext;
    mag      = above ? (target - filt_ext) : (filt_ext - target);
    enable   = active && (mag > {2'd0, cfg_i.deadzone});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (take_o) begin
        out_valid_q <= item_valid_i;
      end
      if (advance) begin
        ring_q[ptr_q] <= item_i.sample;
        ptr_q         <= ptr_d;
        sum_q         <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_enable_q <= enable;
      turn_right_q  <= enable && above;
      pulse_count_q <= enable ? cfg_i.pulses_per_command : 8'd0;
      filtered_q    <= filtered;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign step_enable_o       = step_enable_q;
  assign turn_right_o        = turn_right_q;
  assign pulse_count_o       = pulse_count_q;
  assign filtered_position_o = filtered_q;

endmodule

`default_nettype wire
